// ===== rtl/vwbp_pkg.sv =====
package vwbp_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned AccW      = 39;

  localparam logic [31:0] EmptyValue = 32'hFFFF_FFFF;
  localparam logic [5:0]  MaxWidth   = 6'd32;
  localparam logic [6:0]  HeaderBits = 7'h01;
  localparam logic [2:0]  HeaderLen  = 3'd2;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  width;
    logic        hdr;
    logic        last;
    logic        err;
  } vwbp_entry_t;

  // w is already saturated to 0..32
  function automatic logic [31:0] mask_value(logic [31:0] v, logic [5:0] w);
    logic [32:0] m;
    begin
      m = (33'd1 << w) - 33'd1;
      return (v == EmptyValue) ? 32'd0 : (v & m[31:0]);
    end
  endfunction

endpackage

// ===== rtl/vwbp_front.sv =====
module vwbp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          field_value_i,
  input  logic [5:0]           field_width_i,
  input  logic                 last_field_i,
  input  logic                 push,
  output logic                 full,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output vwbp_pkg::vwbp_entry_t q_entry_o
);
  import vwbp_pkg::*;

  logic       open_q, open_d;
  logic       drop_q, drop_d;
  logic       take;
  logic [5:0] wsat;
  logic       zero_w;

  assign full   = q_full_i;
  assign take   = push && !q_full_i;
  assign zero_w = (field_width_i == 6'd0);
  assign wsat   = (field_width_i > MaxWidth) ? MaxWidth : field_width_i;

  always_comb begin
    q_entry_o.value = mask_value(field_value_i, wsat);
    q_entry_o.width = wsat;
    q_entry_o.hdr   = !open_q;
    q_entry_o.last  = last_field_i;
    q_entry_o.err   = zero_w;
    q_push_o        = take && !drop_q;
  end

  always_comb begin
    open_d = open_q;
    drop_d = drop_q;
    if (take) begin
      if (drop_q) begin
        if (last_field_i) begin
          drop_d = 1'b0;
        end
      end else if (zero_w) begin
        open_d = 1'b0;
        drop_d = !last_field_i;
      end else begin
        open_d = !last_field_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      open_q <= open_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ===== rtl/vwbp_fifo.sv =====
module vwbp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  vwbp_pkg::vwbp_entry_t wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output vwbp_pkg::vwbp_entry_t rdata_o,
  output logic                  valid_o
);
  import vwbp_pkg::*;

  vwbp_entry_t       mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/vwbp_back.sv =====
module vwbp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vwbp_pkg::vwbp_entry_t q_entry_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  output logic [7:0]            out_byte_o,
  output logic                  end_of_record_o,
  output logic                  format_error_o,
  output logic                  empty,
  input  logic                  pop
);
  import vwbp_pkg::*;

  logic [AccW-1:0] acc_q, acc_d;
  logic [5:0]      total_q, total_d;
  logic            busy_q, busy_d;
  logic            last_q, last_d;
  logic            err_q, err_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      obyte_q;
  logic            oeor_q, oerr_q;

  logic            out_rdy, below8, below16, can_emit, emit, done, load;
  logic [6:0]      res_bits, base_bits;
  logic [2:0]      res_cnt, base_cnt;
  logic [AccW-1:0] acc_new;
  logic [5:0]      total_new;

  assign below8   = (total_q[5:3] == 3'd0);
  assign below16  = (total_q[5:4] == 2'd0);
  assign out_rdy  = !ovalid_q || pop;
  assign can_emit = busy_q && (!below8 || last_q);
  assign emit     = can_emit && out_rdy;
  assign done     = !busy_q || (emit && (last_q ? below8 : below16));
  assign load     = done && q_valid_i;
  assign q_pop_o  = load;

  always_comb begin
    if (!busy_q) begin
      res_bits = acc_q[6:0];
      res_cnt  = total_q[2:0];
    end else if (last_q) begin
      res_bits = '0;
      res_cnt  = '0;
    end else begin
      res_bits = acc_q[14:8];
      res_cnt  = total_q[2:0];
    end
    base_bits = q_entry_i.hdr ? HeaderBits : res_bits;
    base_cnt  = q_entry_i.hdr ? HeaderLen : res_cnt;
    acc_new   = {32'd0, base_bits} | ({7'd0, q_entry_i.value} << base_cnt);
    total_new = {3'd0, base_cnt} + q_entry_i.width;
  end

  always_comb begin
    acc_d   = acc_q;
    total_d = total_q;
    busy_d  = busy_q;
    last_d  = last_q;
    err_d   = err_q;
    if (emit) begin
      if (below8) begin
        acc_d   = '0;
        total_d = '0;
      end else begin
        acc_d   = acc_q >> 8;
        total_d = total_q - 6'd8;
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      last_d = q_entry_i.last || q_entry_i.err;
      err_d  = q_entry_i.err;
      if (q_entry_i.err) begin
        acc_d   = '0;
        total_d = '0;
        busy_d  = 1'b1;
      end else begin
        acc_d   = acc_new;
        total_d = total_new;
        busy_d  = q_entry_i.last || (total_new[5:3] != 3'd0);
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (pop) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      total_q  <= '0;
      busy_q   <= 1'b0;
      last_q   <= 1'b0;
      err_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      total_q  <= total_d;
      busy_q   <= busy_d;
      last_q   <= last_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= acc_q[7:0];
      oeor_q  <= last_q && below8;
      oerr_q  <= err_q;
    end
  end

  assign empty           = !ovalid_q;
  assign out_byte_o      = obyte_q;
  assign end_of_record_o = oeor_q;
  assign format_error_o  = oerr_q;

endmodule

// ===== rtl/variable_width_bit_packer.sv =====
// LSB-first variable-width bit packer.
// Input side is a queue write port: present field_value_i, field_width_i and
// last_field_i with push; the transfer happens on a clock edge with push high
// and full low. Each field is one transfer; a record starts with header bits
// 01 and ends on the transfer with last_field_i set.
// Output side is a queue read port: while empty is low the oldest byte is on
// out_byte_o, end_of_record_o and format_error_o; pop takes it.
// A field width of zero yields one byte 0 with end_of_record_o and
// format_error_o set, and the remaining fields of that record are dropped.
// The bytes of a field pass through the queue, the packing register and the
// output register. Throughput: one byte per cycle while pop keeps up; a field
// occupies the packing stage until each byte it completes (1 to 5) has been
// emitted. A 2-entry queue between the field decoder and the packing stage
// lets input transfers continue while bytes drain.
// When pop is held low the output byte holds, the packing stage stalls, and
// full rises once both queue entries are occupied. Reset empties everything
// and the next field opens a new record.
module variable_width_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] field_value_i,
  input  logic [5:0]  field_width_i,
  input  logic        last_field_i,
  input  logic        push,
  output logic        full,
  output logic [7:0]  out_byte_o,
  output logic        end_of_record_o,
  output logic        format_error_o,
  output logic        empty,
  input  logic        pop
);
  import vwbp_pkg::*;

  vwbp_entry_t wr_entry, rd_entry;
  logic        q_push, q_full, q_pop, q_valid;

  vwbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .field_value_i (field_value_i),
    .field_width_i (field_width_i),
    .last_field_i  (last_field_i),
    .push          (push),
    .full          (full),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (wr_entry)
  );

  vwbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (rd_entry),
    .valid_o (q_valid)
  );

  vwbp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_entry_i       (rd_entry),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .out_byte_o      (out_byte_o),
    .end_of_record_o (end_of_record_o),
    .format_error_o  (format_error_o),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

// ===== rtl/vwbp_checker.sv =====
module vwbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [7:0]  out_byte_o,
  input logic        end_of_record_o,
  input logic        format_error_o,
  input logic        empty,
  input logic        pop
);

  // error result closes the record and carries a zero byte
  a_err_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && format_error_o) |-> (end_of_record_o && out_byte_o == 8'd0))
    else $error("error result malformed");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(end_of_record_o)
                          && $stable(format_error_o)))
    else $error("stalled result changed");

  // full only rises right after an input transfer
  a_full_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without a transfer");

  a_flags_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({full, empty}))
    else $error("queue flags unknown");

endmodule

bind variable_width_bit_packer vwbp_checker u_vwbp_checker (.*);
